// ----- sv/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/npf_pkg.sv -----
// ----------------------------------------------------------------------------
// npf_pkg
// Microcode format, step addresses and the control store of the prime finder.
// ----------------------------------------------------------------------------
package npf_pkg;

  localparam int STEP_BITS = 5;
  typedef logic [STEP_BITS-1:0] step_t;

  typedef enum logic [3:0] {
    A_NOP,
    A_LOAD,
    A_SMALL,
    A_MOD6,
    A_FOLD6,
    A_BASE,
    A_CAND_LO,
    A_DIV_D,
    A_DIV_D2,
    A_STEP_D,
    A_NEXT,
    A_FOUND,
    A_PUSH
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_SMALL,
    C_DIV_BUSY,
    C_CAND_LE_V,
    C_DSQ_GT_CAND,
    C_REM_ZERO,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic in_take;
    logic is_small;
    logic div_busy;
    logic cand_le_v;
    logic dsq_gt_cand;
    logic rem_zero;
    logic out_full;
  } flags_t;

  localparam step_t S_WAIT     = 5'd0;
  localparam step_t S_SMALL    = 5'd1;
  localparam step_t S_MOD6     = 5'd2;
  localparam step_t S_FOLD6    = 5'd3;
  localparam step_t S_BASE     = 5'd4;
  localparam step_t S_CAND_LO  = 5'd5;
  localparam step_t S_CHECK    = 5'd6;
  localparam step_t S_BOUND    = 5'd7;
  localparam step_t S_DIV_D    = 5'd8;
  localparam step_t S_DIV_D_W  = 5'd9;
  localparam step_t S_TEST_D   = 5'd10;
  localparam step_t S_DIV_D2   = 5'd11;
  localparam step_t S_DIV_D2_W = 5'd12;
  localparam step_t S_TEST_D2  = 5'd13;
  localparam step_t S_STEP_D   = 5'd14;
  localparam step_t S_NEXT     = 5'd15;
  localparam step_t S_FOUND    = 5'd16;
  localparam step_t S_OUT_W    = 5'd17;
  localparam step_t S_PUSH     = 5'd18;

  function automatic uword_t ucode(input step_t addr);
    uword_t w;
    w = '{act: A_NOP, cond: C_ALWAYS, target: S_WAIT};
    case (addr)
      S_WAIT:     w = '{act: A_LOAD,    cond: C_NO_IN,       target: S_WAIT};
      S_SMALL:    w = '{act: A_SMALL,   cond: C_SMALL,       target: S_OUT_W};
      S_MOD6:     w = '{act: A_MOD6,    cond: C_NEVER,       target: S_WAIT};
      S_FOLD6:    w = '{act: A_FOLD6,   cond: C_NEVER,       target: S_WAIT};
      S_BASE:     w = '{act: A_BASE,    cond: C_NEVER,       target: S_WAIT};
      S_CAND_LO:  w = '{act: A_CAND_LO, cond: C_NEVER,       target: S_WAIT};
      S_CHECK:    w = '{act: A_NOP,     cond: C_CAND_LE_V,   target: S_NEXT};
      S_BOUND:    w = '{act: A_NOP,     cond: C_DSQ_GT_CAND, target: S_FOUND};
      S_DIV_D:    w = '{act: A_DIV_D,   cond: C_NEVER,       target: S_WAIT};
      S_DIV_D_W:  w = '{act: A_NOP,     cond: C_DIV_BUSY,    target: S_DIV_D_W};
      S_TEST_D:   w = '{act: A_NOP,     cond: C_REM_ZERO,    target: S_NEXT};
      S_DIV_D2:   w = '{act: A_DIV_D2,  cond: C_NEVER,       target: S_WAIT};
      S_DIV_D2_W: w = '{act: A_NOP,     cond: C_DIV_BUSY,    target: S_DIV_D2_W};
      S_TEST_D2:  w = '{act: A_NOP,     cond: C_REM_ZERO,    target: S_NEXT};
      S_STEP_D:   w = '{act: A_STEP_D,  cond: C_ALWAYS,      target: S_BOUND};
      S_NEXT:     w = '{act: A_NEXT,    cond: C_ALWAYS,      target: S_CHECK};
      S_FOUND:    w = '{act: A_FOUND,   cond: C_NEVER,       target: S_WAIT};
      S_OUT_W:    w = '{act: A_NOP,     cond: C_OUT_FULL,    target: S_OUT_W};
      S_PUSH:     w = '{act: A_PUSH,    cond: C_ALWAYS,      target: S_WAIT};
      default:    w = '{act: A_NOP,     cond: C_ALWAYS,      target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/npf_div.sv -----
// ----------------------------------------------------------------------------
// npf_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module npf_div #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [W-1:0] rem
);

  localparam int CNT_BITS = $clog2(W + 1);

  logic [W-1:0]        nreg;
  logic [W-1:0]        dreg;
  logic [W-1:0]        rreg;
  logic [CNT_BITS-1:0] count;
  logic [W:0]          r_shift;
  logic [W:0]          diff;
  logic [W-1:0]        r_new;

  always_comb begin
    r_shift = {rreg, nreg[W-1]};
    diff    = r_shift - {1'b0, dreg};
    // keep the shifted remainder when the subtraction borrows
    r_new   = diff[W] ? r_shift[W-1:0] : diff[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && count == CNT_BITS'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nreg  <= num;
      dreg  <= den;
      rreg  <= '0;
      count <= CNT_BITS'(W);
    end else if (busy) begin
      nreg  <= nreg << 1;
      rreg  <= r_new;
      count <= count - CNT_BITS'(1);
    end
  end

  assign rem = rreg;

  `ASSERT_IMPLIES(no_start_while_busy, clk, rst, start, !busy)
  `ASSERT_NEXT(start_sets_busy, clk, rst, start, busy && count == CNT_BITS'(W))
  `ASSERT_IMPLIES(busy_count_live, clk, rst, busy, count != '0)

endmodule

// ----- sv/npf_seq.sv -----
// ----------------------------------------------------------------------------
// npf_seq
// Step counter and control store; picks the next step from the jump condition.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module npf_seq
  import npf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output act_t   act
);

  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   jump;

  always_comb begin
    uw = ucode(step);
    case (uw.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_IN:       jump = !flags.in_take;
      C_SMALL:       jump = flags.is_small;
      C_DIV_BUSY:    jump = flags.div_busy;
      C_CAND_LE_V:   jump = flags.cand_le_v;
      C_DSQ_GT_CAND: jump = flags.dsq_gt_cand;
      C_REM_ZERO:    jump = flags.rem_zero;
      C_OUT_FULL:    jump = flags.out_full;
      default:       jump = 1'b1;
    endcase
    step_next = jump ? uw.target : step + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

  assign act = uw.act;

  `ASSERT_NEXT(take_goes_to_small, clk, rst, step == S_WAIT && flags.in_take,
    step == S_SMALL)
  `ASSERT_IMPLIES(take_only_at_wait, clk, rst, flags.in_take, step == S_WAIT)

endmodule

// ----- sv/next_prime_finder.sv -----
// ----------------------------------------------------------------------------
// next_prime_finder
// Smallest prime strictly above an unsigned value, by 6k+-1 trial division.
// ----------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata carry the request (start_value); m_tvalid,
//   m_tready and m_tdata carry the answer (next_prime). One answer per request,
//   in order. Requests are taken one at a time: s_tready is high only while
//   the sequencer sits in its wait step.
// Search steps:
//   inputs below 5 go from the small-value step straight to the output steps.
//   Otherwise set-up steps (mod 6, fold, base, first candidate) come first, and
//   each candidate costs a bound check plus one remainder run per divisor of
//   each pair 6j-1, 6j+1 tried, up to sqrt(candidate)/6 pairs. The shared
//   bit-serial remainder unit dominates, worst of all for 32-bit values.
// Reset:
//   rst clears the step counter, the divider and the output valid flag.
// Stall:
//   the answer sits in an output register until m_tready; the sequencer
//   waits in its output step and a new request is accepted once it is pushed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module next_prime_finder
  import npf_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [VALUE_BITS-1:0] start_value, rest zero
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [VALUE_BITS:0] next_prime, rest zero
  output logic [((VALUE_BITS+8)/8)*8-1:0]     m_tdata
);

  localparam int OUT_BITS = VALUE_BITS + 1;
  localparam int CW       = VALUE_BITS + 2;
  localparam int OUT_TW   = ((VALUE_BITS + 8) / 8) * 8;
  localparam int NBYTES   = (CW + 7) / 8;

  act_t            act;
  flags_t          flags;
  logic            in_take;
  logic [CW-1:0]   v;
  logic [CW-1:0]   base;
  logic [CW-1:0]   cand;
  logic            hi;
  logic [CW-1:0]   d;
  logic [CW-1:0]   dsq;
  logic [CW-1:0]   res;
  logic [OUT_BITS-1:0] out_data;
  logic            out_valid;
  logic            div_start;
  logic [CW-1:0]   div_num;
  logic [CW-1:0]   div_den;
  logic            div_busy;
  logic [CW-1:0]   div_rem;
  logic [CW-1:0]   vp2;
  logic [NBYTES*8-1:0] vp2_pad;
  logic [11:0]     byte_sum;
  logic [11:0]     m3_sum;
  logic            vp2_odd;
  logic [8:0]      fold_t;
  logic [4:0]      fold_u;
  logic [4:0]      m3;
  logic [2:0]      rem6;
  logic [2:0]      rem6_next;

  assign s_tready = (act == A_LOAD);
  assign in_take  = s_tvalid && s_tready;

  always_comb begin
    flags.in_take     = in_take;
    flags.is_small    = v < CW'(5);
    flags.div_busy    = div_busy;
    flags.cand_le_v   = cand <= v;
    flags.dsq_gt_cand = dsq > cand;
    flags.rem_zero    = div_rem == '0;
    flags.out_full    = out_valid;
  end

  npf_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .act   (act)
  );

  // (v+2) mod 6 from parity and mod 3; 256 and 16 are both 1 mod 3
  assign vp2 = v + CW'(2);

  always_comb begin
    vp2_pad  = (NBYTES*8)'(vp2);
    byte_sum = '0;
    for (int k = 0; k < NBYTES; k++) begin
      byte_sum = byte_sum + 12'(vp2_pad[k*8 +: 8]);
    end
  end

  always_comb begin
    fold_t = 9'(m3_sum[7:0]) + 9'(m3_sum[11:8]);
    fold_u = 5'(fold_t[3:0]) + 5'(fold_t[7:4]) + 5'(fold_t[8]);
    m3     = fold_u;
    if (m3 >= 5'd24) m3 = m3 - 5'd24;
    if (m3 >= 5'd12) m3 = m3 - 5'd12;
    if (m3 >= 5'd6)  m3 = m3 - 5'd6;
    if (m3 >= 5'd3)  m3 = m3 - 5'd3;
    rem6_next = (m3[0] == vp2_odd) ? 3'(m3) : 3'(m3) + 3'd3;
  end

  always_comb begin
    div_start = (act == A_DIV_D) || (act == A_DIV_D2);
    div_num   = cand;
    case (act)
      A_DIV_D: div_den = d;
      default: div_den = d + CW'(2);
    endcase
  end

  npf_div #(.W(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .rem   (div_rem)
  );

  // datapath registers, driven by the current control word
  always_ff @(posedge clk) begin
    case (act)
      A_LOAD: begin
        if (in_take) begin
          v <= CW'(s_tdata[VALUE_BITS-1:0]);
        end
      end
      A_SMALL: begin
        if (v < CW'(2)) begin
          res <= CW'(2);
        end else if (v < CW'(3)) begin
          res <= CW'(3);
        end else begin
          res <= CW'(5);
        end
      end
      A_MOD6: begin
        m3_sum  <= byte_sum;
        vp2_odd <= vp2[0];
      end
      A_FOLD6: begin
        rem6 <= rem6_next;
      end
      A_BASE: begin
        // base is the largest multiple of six not above v+2
        base <= vp2 - CW'(rem6);
      end
      A_CAND_LO: begin
        cand <= base - CW'(1);
        hi   <= 1'b0;
        d    <= CW'(5);
        dsq  <= CW'(25);
      end
      A_STEP_D: begin
        // (d+6)^2 = d^2 + 12d + 36
        d   <= d + CW'(6);
        dsq <= dsq + (d << 3) + (d << 2) + CW'(36);
      end
      A_NEXT: begin
        if (!hi) begin
          cand <= base + CW'(1);
          hi   <= 1'b1;
        end else begin
          base <= base + CW'(6);
          cand <= base + CW'(5);
          hi   <= 1'b0;
        end
        d   <= CW'(5);
        dsq <= CW'(25);
      end
      A_FOUND: begin
        res <= cand;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (act == A_PUSH) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act == A_PUSH) begin
      out_data <= res[OUT_BITS-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TW'(out_data);

  `ASSERT_IMPLIES(push_into_empty, clk, rst, act == A_PUSH, !out_valid)
  `ASSERT_IMPLIES(idle_divider_on_take, clk, rst, in_take, !div_busy)

endmodule

// ----- tb/tb_next_prime_finder.sv -----
// ----------------------------------------------------------------------------
// tb_next_prime_finder
// Feeds start values through the request stream and checks every answer against
// a known value or a trial-division predictor, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_next_prime_finder;

  localparam int VALUE_BITS      = 32;
  localparam int RANDOM_REQUESTS = 100;
  localparam int QUIET_LIMIT     = 4000000;
  localparam int PROBE_COUNT     = 20;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS:0]   known;   // zero: take the predictor's answer
  } probe_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [31:0] start_value
  logic [31:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [32:0] next_prime, [39:33] zero
  logic [39:0]           m_tdata;

  logic [VALUE_BITS:0]   primes_due [$];
  logic [VALUE_BITS:0]   due_prime;
  int                    mismatches = 0;
  int                    quiet_cycles = 0;
  bit                    steady = 1'b0;

  probe_t probes [PROBE_COUNT] = '{
    '{32'd0,          33'd2},
    '{32'd1,          33'd2},
    '{32'd2,          33'd3},
    '{32'd3,          33'd5},
    '{32'd4,          33'd5},
    '{32'd5,          33'd7},
    '{32'd6,          33'd0},
    '{32'd7,          33'd0},
    '{32'd10,         33'd0},
    '{32'd11,         33'd0},
    '{32'd12,         33'd0},
    '{32'd23,         33'd0},
    '{32'd24,         33'd0},
    '{32'd25,         33'd0},
    '{32'd120,        33'd0},
    '{32'd1000,       33'd0},
    '{32'h0000ffff,   33'd0},
    '{32'h00aaaaaa,   33'd0},
    '{32'h00555555,   33'd0},
    // answer needs the extra output bit
    '{32'hffffffff,   33'd4294967311}
  };

  next_prime_finder #(
    .VALUE_BITS (VALUE_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // candidate c >= 5 of the form 6k+-1, divisors 6j-1 and 6j+1
  function automatic bit has_no_divisor(input longint unsigned c);
    longint unsigned d;
    for (d = 5; d * d <= c; d += 6) begin
      if (c % d == 0 || c % (d + 2) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [VALUE_BITS:0] next_prime_above(input logic [VALUE_BITS-1:0] v);
    longint unsigned val;
    longint unsigned base;
    val = 64'(v);
    if (val < 2) return (VALUE_BITS+1)'(2);
    if (val < 3) return (VALUE_BITS+1)'(3);
    if (val < 5) return (VALUE_BITS+1)'(5);
    base = 6 * ((val + 2) / 6);
    while (1) begin
      if (base - 1 > val && has_no_divisor(base - 1)) return (VALUE_BITS+1)'(base - 1);
      if (base + 1 > val && has_no_divisor(base + 1)) return (VALUE_BITS+1)'(base + 1);
      base += 6;
    end
  endfunction

  task automatic offer_value(input logic [VALUE_BITS-1:0] v, input logic [VALUE_BITS:0] want);
    while (!steady && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    primes_due.push_back(want);
  endtask

  // answer checking, receiver stalls and the no-progress watchdog
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 8);
      if (m_tvalid && m_tready) begin
        if (primes_due.size() == 0) begin
          $display("%0t: unexpected answer, expected none, got %0d", $time, m_tdata[32:0]);
          mismatches++;
        end else begin
          due_prime = primes_due.pop_front();
          if (m_tdata[32:0] !== due_prime) begin
            $display("%0t: next_prime mismatch, expected %0d, got %0d",
                     $time, due_prime, m_tdata[32:0]);
            mismatches++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned          i;
    int unsigned          spread;
    logic [VALUE_BITS-1:0] v;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < PROBE_COUNT; i++) begin
      offer_value(probes[i].value,
                  probes[i].known != 0 ? probes[i].known : next_prime_above(probes[i].value));
    end

    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      // hold off until every answer so far is back
      if (i == 40) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (primes_due.size() != 0);
      end
      steady = (i >= 60 && i < 90);
      // mostly small values: the search cost grows with the square root
      spread = $urandom_range(0, 99);
      if (spread < 70) v = $urandom_range(0, 4095);
      else if (spread < 90) v = $urandom_range(0, 65535);
      else if (spread < 98) v = $urandom_range(0, 20'hfffff);
      else v = $urandom_range(0, 24'hffffff);
      offer_value(v, next_prime_above(v));
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    while (primes_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
